// File: src/ksha1_pkg.sv
// Shared types, constants and round functions of the keyed SHA-1 block.
`default_nettype none

package ksha1_pkg;

    localparam int WORD_W     = 32;
    localparam int KEY_COUNT  = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int BLOCK_WORDS = 16;
    localparam int PHASE_LEN  = 20;
    localparam int PHASE_CNT_W = 5;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [KEY_COUNT-1:0][WORD_W-1:0] key_array_t;
    typedef logic [1:0] phase_t;

    // Round phases, each twenty rounds long.
    localparam phase_t PH_CHOOSE   = 2'd0;
    localparam phase_t PH_PARITY_A = 2'd1;
    localparam phase_t PH_MAJORITY = 2'd2;
    localparam phase_t PH_PARITY_B = 2'd3;

    // Initial chaining values.
    localparam word_t IV_A = 32'h6745_2301;
    localparam word_t IV_B = 32'hefcd_ab89;
    localparam word_t IV_C = 32'h98ba_dcfe;
    localparam word_t IV_D = 32'h1032_5476;
    localparam word_t IV_E = 32'hc3d2_e1f0;

    // Fixed block content around the data and key words.
    localparam word_t PAD_WORD   = 32'h8000_0000;
    localparam word_t LENGTH_BITS = 32'd288;
    localparam word_t KEY_RESET_BASE = 32'd49;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   load;
        logic   step;
        phase_t phase;
        logic   store;
    } cmd_t;

    function automatic word_t round_k(input phase_t phase);
        word_t k;
        unique case (phase)
            PH_CHOOSE:   k = 32'h5A82_7999;
            PH_PARITY_A: k = 32'h6ED9_EBA1;
            PH_MAJORITY: k = 32'h8F1B_BCDC;
            PH_PARITY_B: k = 32'hCA62_C1D6;
            default:     k = 32'hCA62_C1D6;
        endcase
        return k;
    endfunction

    function automatic word_t round_f(input phase_t phase, input word_t b,
                                      input word_t c, input word_t d);
        word_t f;
        unique case (phase)
            PH_CHOOSE:   f = (b & c) | (~b & d);
            PH_MAJORITY: f = (b & c) | (b & d) | (c & d);
            PH_PARITY_A: f = b ^ c ^ d;
            PH_PARITY_B: f = b ^ c ^ d;
            default:     f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// File: src/ksha1_ctrl.sv
// Controller: handshakes, round and phase counters, output valid flag.
`default_nettype none

module ksha1_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output ksha1_pkg::cmd_t      cmd
);
    import ksha1_pkg::*;

    state_t                 state_reg, state_next;
    logic [PHASE_CNT_W-1:0] cnt_reg, cnt_next;
    phase_t                 phase_reg, phase_next;
    logic                   out_valid_reg, out_valid_next;

    // State, counters and output flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= PH_CHOOSE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        in_ready       = 1'b0;
        cmd.load       = 1'b0;
        cmd.step       = 1'b0;
        cmd.store      = 1'b0;
        cmd.phase      = phase_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    phase_next = PH_CHOOSE;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.step = 1'b1;
                if (cnt_reg == PHASE_CNT_W'(PHASE_LEN - 1))
                begin
                    cnt_next   = '0;
                    phase_next = phase_reg + 2'd1;
                    if (phase_reg == PH_PARITY_B)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                // Hand the digest over once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.store      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: src/ksha1_dp.sv
// Datapath: schedule window, working variables, round logic and digest register.
`default_nettype none

module ksha1_dp
(
    input  wire logic                  clk,
    input  wire ksha1_pkg::cmd_t       cmd,
    input  wire ksha1_pkg::word_t      data_word,
    input  wire ksha1_pkg::key_array_t key_words,
    output ksha1_pkg::word_t           digest_a,
    output ksha1_pkg::word_t           digest_b,
    output ksha1_pkg::word_t           digest_c,
    output ksha1_pkg::word_t           digest_d,
    output ksha1_pkg::word_t           digest_e
);
    import ksha1_pkg::*;

    word_t win_reg [BLOCK_WORDS];
    word_t win_next [BLOCK_WORDS];
    word_t a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t a_next, b_next, c_next, d_next, e_next;
    word_t dig_a_reg, dig_b_reg, dig_c_reg, dig_d_reg, dig_e_reg;
    word_t sched_mix;
    word_t temp;

    // Next schedule word and round sum.
    always_comb
    begin
        sched_mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        temp = {a_reg[26:0], a_reg[31:27]} + round_f(cmd.phase, b_reg, c_reg, d_reg)
             + e_reg + round_k(cmd.phase) + win_reg[0];
    end

    // Load the block, step one round, or hold.
    always_comb
    begin
        for (int j = 0; j < BLOCK_WORDS; j++)
        begin
            win_next[j] = win_reg[j];
        end
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;

        if (cmd.load)
        begin
            win_next[0] = data_word;
            for (int j = 0; j < KEY_COUNT; j++)
            begin
                win_next[j + 1] = key_words[j];
            end
            win_next[KEY_COUNT + 1] = PAD_WORD;
            for (int j = KEY_COUNT + 2; j < BLOCK_WORDS - 1; j++)
            begin
                win_next[j] = '0;
            end
            win_next[BLOCK_WORDS - 1] = LENGTH_BITS;
            a_next = IV_A;
            b_next = IV_B;
            c_next = IV_C;
            d_next = IV_D;
            e_next = IV_E;
        end
        else if (cmd.step)
        begin
            for (int j = 0; j < BLOCK_WORDS - 1; j++)
            begin
                win_next[j] = win_reg[j + 1];
            end
            win_next[BLOCK_WORDS - 1] = {sched_mix[30:0], sched_mix[31]};
            a_next = temp;
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[31:2]};
            d_next = c_reg;
            e_next = d_reg;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < BLOCK_WORDS; j++)
        begin
            win_reg[j] <= win_next[j];
        end
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
    end

    // Digest register: initial values added to the final variables.
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            dig_a_reg <= IV_A + a_reg;
            dig_b_reg <= IV_B + b_reg;
            dig_c_reg <= IV_C + c_reg;
            dig_d_reg <= IV_D + d_reg;
            dig_e_reg <= IV_E + e_reg;
        end
    end

    assign digest_a = dig_a_reg;
    assign digest_b = dig_b_reg;
    assign digest_c = dig_c_reg;
    assign digest_d = dig_d_reg;
    assign digest_e = dig_e_reg;

endmodule

`default_nettype wire

// File: src/keyed_sha1_single_block.sv
// Top level of the keyed single-block SHA-1 hasher: key registers and the two halves.
//
//  Channel   Signals                                   Direction
//  input     in_valid, in_ready, data_word             beat in
//  output    out_valid, out_ready, digest_a..digest_e  beat out
//  config    cfg_we, cfg_index, cfg_data               write only
//
// Each item is loaded into the block, runs 80 rounds at one per cycle through the
// single round unit, then has the initial values added into the output register
// once that is free. in_ready is high only while no hash is in progress; a digest
// that waits in the output register does not hold back the next beat's rounds.
// Reset returns the key registers to 49..56 and clears the controller.
`default_nettype none

module keyed_sha1_single_block
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire ksha1_pkg::word_t               data_word,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output ksha1_pkg::word_t                    digest_a,
    output ksha1_pkg::word_t                    digest_b,
    output ksha1_pkg::word_t                    digest_c,
    output ksha1_pkg::word_t                    digest_d,
    output ksha1_pkg::word_t                    digest_e,
    input  wire logic                           cfg_we,
    input  wire logic [ksha1_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire ksha1_pkg::word_t               cfg_data
);
    import ksha1_pkg::*;

    key_array_t key_reg;
    cmd_t       cmd;

    // Key registers; writes to indexes past the last key are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_COUNT; i++)
            begin
                key_reg[i] <= KEY_RESET_BASE + WORD_W'(i);
            end
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(KEY_COUNT)))
        begin
            key_reg[cfg_index[$clog2(KEY_COUNT)-1:0]] <= cfg_data;
        end
    end

    ksha1_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    ksha1_dp u_dp
    (
        .clk       (clk),
        .cmd       (cmd),
        .data_word (data_word),
        .key_words (key_reg),
        .digest_a  (digest_a),
        .digest_b  (digest_b),
        .digest_c  (digest_c),
        .digest_d  (digest_d),
        .digest_e  (digest_e)
    );

endmodule

`default_nettype wire

// File: bench/tb_keyed_sha1_single_block.sv
// Self-checking testbench for the keyed single-block SHA-1 hasher.
`timescale 1ns / 100ps

module tb_keyed_sha1_single_block;

    import ksha1_pkg::*;

    // Five digest words, index 0 holding digest_a.
    typedef word_t [4:0] digest_t;

    localparam digest_t IV_WORDS = {32'hc3d2_e1f0, 32'h1032_5476, 32'h98ba_dcfe,
                                    32'hefcd_ab89, 32'h6745_2301};
    localparam word_t K_CHOOSE   = 32'h5A82_7999;
    localparam word_t K_PARITY_A = 32'h6ED9_EBA1;
    localparam word_t K_MAJORITY = 32'h8F1B_BCDC;
    localparam word_t K_PARITY_B = 32'hCA62_C1D6;
    localparam word_t PAD_MARK   = 32'h8000_0000;
    localparam word_t BIT_LENGTH = 32'd288;
    localparam int    ROUNDS     = 80;

    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 250;

    // Holds a copy of the key registers and the digests still owed by the block.
    class digest_board;
        word_t   key_regs[KEY_COUNT];
        digest_t digests_due[$];
        int      mismatches;
        string   field_name[5] = '{"digest_a", "digest_b", "digest_c", "digest_d",
                                   "digest_e"};

        function new();
            for (int i = 0; i < KEY_COUNT; i++)
                key_regs[i] = 32'd49 + i;
            mismatches = 0;
        endfunction

        function void write_reg(int idx, word_t val);
            if (idx < KEY_COUNT)
                key_regs[idx] = val;
        endfunction

        function int pending();
            return digests_due.size();
        endfunction

        // Hashes the one padded block built from the data word and the keys.
        function digest_t keyed_digest(word_t msg);
            word_t   sched[ROUNDS];
            word_t   a, b, c, d, e, f, k, t, x;
            phase_t  ph;
            digest_t dg;
            sched[0] = msg;
            for (int i = 0; i < KEY_COUNT; i++)
                sched[i + 1] = key_regs[i];
            sched[9] = PAD_MARK;
            for (int i = 10; i < 15; i++)
                sched[i] = '0;
            sched[15] = BIT_LENGTH;
            for (int i = 16; i < ROUNDS; i++)
            begin
                x = sched[i - 3] ^ sched[i - 8] ^ sched[i - 14] ^ sched[i - 16];
                sched[i] = {x[30:0], x[31]};
            end
            a = IV_WORDS[0];
            b = IV_WORDS[1];
            c = IV_WORDS[2];
            d = IV_WORDS[3];
            e = IV_WORDS[4];
            for (int i = 0; i < ROUNDS; i++)
            begin
                ph = phase_t'(i / 20);
                case (ph)
                    PH_CHOOSE:
                    begin
                        f = (b & c) | (~b & d);
                        k = K_CHOOSE;
                    end
                    PH_PARITY_A:
                    begin
                        f = b ^ c ^ d;
                        k = K_PARITY_A;
                    end
                    PH_MAJORITY:
                    begin
                        f = (b & c) | (b & d) | (c & d);
                        k = K_MAJORITY;
                    end
                    default:
                    begin
                        f = b ^ c ^ d;
                        k = K_PARITY_B;
                    end
                endcase
                t = {a[26:0], a[31:27]} + f + e + k + sched[i];
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = t;
            end
            dg[0] = IV_WORDS[0] + a;
            dg[1] = IV_WORDS[1] + b;
            dg[2] = IV_WORDS[2] + c;
            dg[3] = IV_WORDS[3] + d;
            dg[4] = IV_WORDS[4] + e;
            return dg;
        endfunction

        function void note_input(word_t msg);
            digests_due.push_back(keyed_digest(msg));
        endfunction

        function void check_digest(digest_t got);
            digest_t want;
            if (digests_due.size() == 0)
            begin
                $display("%0t: digest beat with nothing outstanding, got %h", $time, got);
                mismatches++;
                return;
            end
            want = digests_due.pop_front();
            for (int i = 0; i < 5; i++)
            begin
                if (got[i] !== want[i])
                begin
                    $display("%0t: %s mismatch: expected %08h, got %08h", $time,
                             field_name[i], want[i], got[i]);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    word_t                data_word = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    word_t                digest_a, digest_b, digest_c, digest_d, digest_e;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    word_t                cfg_data  = '0;

    bit          idle_on  = 1'b1;
    bit          hold_req = 1'b0;
    digest_board board;

    keyed_sha1_single_block uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_word (data_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .digest_a  (digest_a),
        .digest_b  (digest_b),
        .digest_c  (digest_c),
        .digest_d  (digest_d),
        .digest_e  (digest_e),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs or loses a digest.
    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // Output side: random stalls, plus one long hold-off when asked for.
    initial
    begin
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Every accepted digest beat is checked against the oldest outstanding one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_digest({digest_e, digest_d, digest_c, digest_b, digest_a});
    end

    // Offers one data word, after an optional gap, and waits for its beat.
    task automatic send_word(input word_t w);
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_word <= w;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_input(w);
    endtask

    // Stops offering and waits until every digest is in and the block is idle.
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all eight key words, then a stray write to an unused index.
    task automatic write_keys(input word_t vals[KEY_COUNT]);
        logic [CFG_IDX_W-1:0] idx;
        word_t                junk;
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data  <= vals[i];
            @(posedge clk);
            board.write_reg(i, vals[i]);
        end
        idx  = CFG_IDX_W'($urandom_range(KEY_COUNT, 2 ** CFG_IDX_W - 1));
        junk = $urandom();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= junk;
        @(posedge clk);
        board.write_reg(int'(idx), junk);
        cfg_we <= 1'b0;
    endtask

    // Main sequence: directed corners first, then randomised phases.
    initial
    begin : stimulus
        word_t keys[KEY_COUNT];
        word_t corner_words[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                   32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
                                   32'h7FFF_FFFF, 32'hFFFF_FFFE};
        word_t w;
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner data words under the reset key.
        foreach (corner_words[i])
            send_word(corner_words[i]);
        settle();

        // All-zero key.
        foreach (keys[i])
            keys[i] = '0;
        write_keys(keys);
        send_word('0);
        send_word('1);
        send_word(32'h8000_0000);
        settle();

        // All-ones key; the stray write must leave it untouched.
        foreach (keys[i])
            keys[i] = '1;
        write_keys(keys);
        send_word('0);
        send_word('1);
        settle();

        // Alternating bit patterns across the key words.
        foreach (keys[i])
            keys[i] = i[0] ? 32'h5555_5555 : 32'hAAAA_AAAA;
        write_keys(keys);
        send_word(32'h1234_5678);
        send_word(32'hEDCB_A987);

        // Random phases, each under a new key; the last one runs without gaps.
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            foreach (keys[i])
            begin
                if (p == 3)
                    keys[i] = 32'd49 + i;
                else
                begin
                    case ($urandom_range(0, 7))
                        0:       keys[i] = '0;
                        1:       keys[i] = '1;
                        default: keys[i] = $urandom();
                    endcase
                end
            end
            write_keys(keys);
            idle_on = (p < PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 1 && n == 40)
                    hold_req = 1'b1;
                case ($urandom_range(0, 15))
                    0:       w = '0;
                    1:       w = '1;
                    default: w = $urandom();
                endcase
                send_word(w);
            end
        end
        settle();

        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
